// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising edge outside reset.
`define NBTP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("nbtp assertion failed");

// Check that a condition never holds outside reset.
`define NBTP_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("nbtp forbidden condition seen");

`endif

// ===== hw/rtl/nbtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nbtp_pkg;

   // Parser phases
   localparam logic [2:0] PH_TYPE     = 3'd0;
   localparam logic [2:0] PH_NAMELEN  = 3'd1;
   localparam logic [2:0] PH_NAME     = 3'd2;
   localparam logic [2:0] PH_VALUE    = 3'd3;
   localparam logic [2:0] PH_LISTTYPE = 3'd4;
   localparam logic [2:0] PH_COUNT    = 3'd5;
   localparam logic [2:0] PH_PAYLOAD  = 3'd6;

   // Tag type ids
   localparam logic [3:0] TAG_END        = 4'd0;
   localparam logic [3:0] TAG_BYTE       = 4'd1;
   localparam logic [3:0] TAG_SHORT      = 4'd2;
   localparam logic [3:0] TAG_INT        = 4'd3;
   localparam logic [3:0] TAG_LONG       = 4'd4;
   localparam logic [3:0] TAG_FLOAT      = 4'd5;
   localparam logic [3:0] TAG_DOUBLE     = 4'd6;
   localparam logic [3:0] TAG_BYTE_ARRAY = 4'd7;
   localparam logic [3:0] TAG_STRING     = 4'd8;
   localparam logic [3:0] TAG_LIST       = 4'd9;
   localparam logic [3:0] TAG_COMPOUND   = 4'd10;
   localparam logic [3:0] TAG_INT_ARRAY  = 4'd11;
   localparam logic [3:0] TAG_LONG_ARRAY = 4'd12;

   // Verdict status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TRUNCATED   = 3'd1;
   localparam logic [2:0] ST_UNKNOWN     = 3'd2;
   localparam logic [2:0] ST_NEG_COUNT   = 3'd3;
   localparam logic [2:0] ST_LIST_UNSUPP = 3'd4;

   // Record kinds
   localparam logic REC_TAG     = 1'b0;
   localparam logic REC_VERDICT = 1'b1;

   // Name length field is two bytes
   localparam logic [3:0] NAME_LEN_BYTES = 4'd2;

   // Everything one input byte produces: an optional tag record, then an
   // optional end-of-buffer verdict.
   typedef struct packed {
      logic        has_tag;
      logic [3:0]  tag_type;
      logic [15:0] name_length;
      logic [63:0] scalar_bits;
      logic [30:0] element_count;
      logic [7:0]  list_element_type;
      logic        has_verdict;
      logic [2:0]  verdict_status;
   } group_type;

   // Parser status seen by the top level
   typedef struct packed {
      logic idle;
      logic push;
   } parser_status_type;

   // Bytes in the value of a scalar tag
   function automatic logic [3:0] scalar_size(input logic [3:0] t);
      logic [3:0] s;
      case (t)
         TAG_BYTE:  s = 4'd1;
         TAG_SHORT: s = 4'd2;
         TAG_INT:   s = 4'd4;
         TAG_LONG:  s = 4'd8;
         TAG_FLOAT: s = 4'd4;
         default:   s = 4'd8;
      endcase
      return s;
   endfunction

   // log2 of the element size of an array tag
   function automatic logic [1:0] elem_shift(input logic [3:0] t);
      logic [1:0] s;
      case (t)
         TAG_INT_ARRAY:  s = 2'd2;
         TAG_LONG_ARRAY: s = 2'd3;
         default:        s = 2'd0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nbtp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nbtp_parser
   import nbtp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              last_byte,
   output group_type              group,
   output parser_status_type      status
);

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  type_ff, type_in;
   logic [15:0] name_left_ff, name_left_in;
   logic [15:0] nlen_ff, nlen_in;
   logic [3:0]  idx_ff, idx_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [34:0] pay_left_ff, pay_left_in;
   logic [7:0]  ltype_ff, ltype_in;
   logic [2:0]  err_ff, err_in;

   logic        body_start;
   logic [3:0]  idx_inc;
   logic [31:0] cnt_next;
   logic [34:0] pay_bytes;

   always_comb begin
      phase_in    = phase_ff;
      type_in     = type_ff;
      name_left_in = name_left_ff;
      nlen_in     = nlen_ff;
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      pay_left_in = pay_left_ff;
      ltype_in    = ltype_ff;
      err_in      = err_ff;
      body_start  = 1'b0;
      idx_inc     = idx_ff + 4'd1;
      cnt_next    = cnt_ff | (32'(data_byte) << {idx_ff[1:0], 3'b000});
      pay_bytes   = 35'(cnt_next) << elem_shift(type_ff);

      group                   = '0;
      group.tag_type          = type_ff;
      group.name_length       = nlen_ff;

      // Advance the tag parse while no error is held
      if (accept && (err_ff == ST_OK)) begin
         case (phase_ff)
            PH_TYPE: begin
               if (data_byte == 8'd0) begin
                  group.has_tag     = 1'b1;
                  group.tag_type    = TAG_END;
                  group.name_length = 16'd0;
               end else if (data_byte > 8'(TAG_LONG_ARRAY)) begin
                  err_in = ST_UNKNOWN;
               end else begin
                  type_in  = data_byte[3:0];
                  idx_in   = 4'd0;
                  nlen_in  = 16'd0;
                  phase_in = PH_NAMELEN;
               end
            end
            PH_NAMELEN: begin
               nlen_in = nlen_ff | (16'(data_byte) << {idx_ff[0], 3'b000});
               idx_in  = idx_inc;
               group.name_length = nlen_in;
               if (idx_inc >= NAME_LEN_BYTES) begin
                  name_left_in = nlen_in;
                  if (nlen_in == 16'd0) begin
                     body_start = 1'b1;
                  end else begin
                     phase_in = PH_NAME;
                  end
               end
            end
            PH_NAME: begin
               name_left_in = name_left_ff - 16'd1;
               if (name_left_in == 16'd0) begin
                  body_start = 1'b1;
               end
            end
            PH_VALUE: begin
               acc_in = acc_ff | (64'(data_byte) << {idx_ff[2:0], 3'b000});
               idx_in = idx_inc;
               if (idx_inc >= scalar_size(type_ff)) begin
                  group.has_tag     = 1'b1;
                  group.scalar_bits = acc_in;
                  phase_in          = PH_TYPE;
               end
            end
            PH_LISTTYPE: begin
               ltype_in = data_byte;
               idx_in   = 4'd0;
               cnt_in   = 32'd0;
               phase_in = PH_COUNT;
            end
            PH_COUNT: begin
               cnt_in = cnt_next;
               idx_in = idx_inc;
               if (idx_inc >= ((type_ff == TAG_STRING) ? 4'd2 : 4'd4)) begin
                  if ((type_ff != TAG_STRING) && cnt_next[31]) begin
                     err_in = ST_NEG_COUNT;
                  end else if (type_ff == TAG_LIST) begin
                     group.has_tag           = 1'b1;
                     group.element_count     = cnt_next[30:0];
                     group.list_element_type = ltype_ff;
                     err_in                  = ST_LIST_UNSUPP;
                  end else begin
                     pay_left_in = pay_bytes;
                     if (cnt_next == 32'd0) begin
                        group.has_tag = 1'b1;
                        phase_in      = PH_TYPE;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               pay_left_in = pay_left_ff - 35'd1;
               if (pay_left_in == 35'd0) begin
                  group.has_tag       = 1'b1;
                  group.element_count = cnt_ff[30:0];
                  phase_in            = PH_TYPE;
               end
            end
            default: begin
               phase_in = PH_TYPE;
            end
         endcase
      end

      // Start the tag body once the name is skipped
      if (body_start) begin
         idx_in = 4'd0;
         acc_in = 64'd0;
         cnt_in = 32'd0;
         if (type_ff == TAG_COMPOUND) begin
            group.has_tag = 1'b1;
            phase_in      = PH_TYPE;
         end else if ((type_ff >= TAG_BYTE) && (type_ff <= TAG_DOUBLE)) begin
            phase_in = PH_VALUE;
         end else if (type_ff == TAG_LIST) begin
            phase_in = PH_LISTTYPE;
         end else begin
            phase_in = PH_COUNT;
         end
      end

      // Close the buffer: give the verdict and return to reset state
      if (accept && last_byte) begin
         group.has_verdict = 1'b1;
         if (err_in != ST_OK) begin
            group.verdict_status = err_in;
         end else if (phase_in != PH_TYPE) begin
            group.verdict_status = ST_TRUNCATED;
         end else begin
            group.verdict_status = ST_OK;
         end
         phase_in     = PH_TYPE;
         type_in      = TAG_END;
         name_left_in = 16'd0;
         nlen_in      = 16'd0;
         idx_in       = 4'd0;
         acc_in       = 64'd0;
         cnt_in       = 32'd0;
         pay_left_in  = 35'd0;
         ltype_in     = 8'd0;
         err_in       = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         type_ff      <= TAG_END;
         name_left_ff <= 16'd0;
         nlen_ff      <= 16'd0;
         idx_ff       <= 4'd0;
         acc_ff       <= 64'd0;
         cnt_ff       <= 32'd0;
         pay_left_ff  <= 35'd0;
         ltype_ff     <= 8'd0;
         err_ff       <= ST_OK;
      end else begin
         phase_ff     <= phase_in;
         type_ff      <= type_in;
         name_left_ff <= name_left_in;
         nlen_ff      <= nlen_in;
         idx_ff       <= idx_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         pay_left_ff  <= pay_left_in;
         ltype_ff     <= ltype_in;
         err_ff       <= err_in;
      end
   end

   assign status.idle = (phase_ff == PH_TYPE) && (err_ff == ST_OK);
   assign status.push = accept && (group.has_tag || group.has_verdict);

endmodule

`default_nettype wire

// ===== hw/rtl/nbtp_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nbtp_out_queue
   import nbtp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire group_type   push_group,
   output logic             full,
   output logic             out_valid,
   input  wire logic        out_stall,
   output logic             out_record_kind,
   output logic [3:0]       out_tag_type,
   output logic [15:0]      out_name_length,
   output logic [63:0]      out_scalar_bits,
   output logic [30:0]      out_element_count,
   output logic [7:0]       out_list_element_type,
   output logic [2:0]       out_status,
   output logic             out_last_result
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   group_type         store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              sub_ff, sub_in;

   group_type head;
   logic      on_tag;
   logic      take;
   logic      pop;

   assign head      = store_ff[rd_ptr_ff];
   assign out_valid = (count_ff != '0);
   assign full      = (count_ff == FULL_CNT);

   // Select the tag record first, then the verdict
   assign on_tag = head.has_tag && !sub_ff;

   always_comb begin
      if (on_tag) begin
         out_record_kind       = REC_TAG;
         out_tag_type          = head.tag_type;
         out_name_length       = head.name_length;
         out_scalar_bits       = head.scalar_bits;
         out_element_count     = head.element_count;
         out_list_element_type = head.list_element_type;
         out_status            = ST_OK;
         out_last_result       = !head.has_verdict;
      end else begin
         out_record_kind       = REC_VERDICT;
         out_tag_type          = TAG_END;
         out_name_length       = 16'd0;
         out_scalar_bits       = 64'd0;
         out_element_count     = 31'd0;
         out_list_element_type = 8'd0;
         out_status            = head.verdict_status;
         out_last_result       = 1'b1;
      end
   end

   assign take = out_valid && !out_stall;
   assign pop  = take && out_last_result;

   // Advance pointers, sub-record index and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      sub_in    = sub_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         sub_in    = 1'b0;
      end else if (take) begin
         sub_in = 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   // Hold result groups
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/nbt_tag_stream_parser_core.sv =====
// Little-endian NBT tag stream parser. One buffer byte is taken per cycle
// on the req channel; a byte that completes a tag gives a tag record, and the
// byte marked last also gives a verdict record, so one byte yields zero, one
// or two records on the rsp channel, one per unstalled cycle. Parsing of a
// byte is done in the cycle it is accepted and its records are written to an
// output queue of QUEUE_DEPTH byte-result entries; the first record can be
// taken in the cycle after its byte. req_stall rises only while that queue is
// full, so input runs at one byte per cycle as long as the output side takes
// the records as fast as they are made (at most two per byte, one per cycle).
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nbt_tag_stream_parser_core
   import nbtp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_record_kind,
   output logic [3:0]       rsp_tag_type,
   output logic [15:0]      rsp_name_length,
   output logic [63:0]      rsp_scalar_bits,
   output logic [30:0]      rsp_element_count,
   output logic [7:0]       rsp_list_element_type,
   output logic [2:0]       rsp_status,
   output logic             rsp_last_result
);

   logic              accept;
   logic              queue_full;
   group_type         group;
   parser_status_type parse_status;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   nbtp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .group     (group),
      .status    (parse_status)
   );

   nbtp_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (parse_status.push),
      .push_group            (group),
      .full                  (queue_full),
      .out_valid             (rsp_valid),
      .out_stall             (rsp_stall),
      .out_record_kind       (rsp_record_kind),
      .out_tag_type          (rsp_tag_type),
      .out_name_length       (rsp_name_length),
      .out_scalar_bits       (rsp_scalar_bits),
      .out_element_count     (rsp_element_count),
      .out_list_element_type (rsp_list_element_type),
      .out_status            (rsp_status),
      .out_last_result       (rsp_last_result)
   );

   // A verdict is always the final record of its byte
   `NBTP_ASSERT(a_verdict_last, clock, reset, (rsp_valid && rsp_record_kind) |-> rsp_last_result)
   // Tag records never carry an error status
   `NBTP_ASSERT(a_tag_status_ok, clock, reset, (rsp_valid && !rsp_record_kind) |-> (rsp_status == ST_OK))
   // The parser is back at a tag boundary after a buffer closes
   `NBTP_ASSERT(a_idle_after_last, clock, reset, (req_valid && !req_stall && req_last_byte) |=> parse_status.idle)
   // Input is held back only while records are waiting
   `NBTP_ASSERT_NEVER(a_stall_needs_data, clock, reset, req_stall && !rsp_valid)

endmodule

`default_nettype wire
